[hw/rtl/mmps_pkg.sv]
`default_nettype none
package mmps_pkg;

    localparam int MatrixDim = 5;
    localparam int Cells = MatrixDim * MatrixDim;
    localparam int ExpBitsDefault = 51;
    localparam int LengthWidth = 52;
    localparam int ValueWidth = 30;
    localparam int AddrWidth = 7;

    localparam logic [ValueWidth-1:0] Modulus = 30'd999999937;
    // Barrett constant floor(2^60 / Modulus).
    localparam logic [30:0] BarrettM = 31'((64'd1 << 60) / 64'(Modulus));

    // Regions of the shared matrix memory.
    localparam logic [AddrWidth-1:0] SquareBase  = 7'd0;
    localparam logic [AddrWidth-1:0] AccumBase   = 7'd25;
    localparam logic [AddrWidth-1:0] ProductBase = 7'd50;

    typedef struct packed {
        logic       first;
        logic       last;
        logic [4:0] idx;
    } mmps_tag_t;

    function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
        cell_index = 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    // Fixed transition matrix: rows three and four have zeros in columns two and four.
    function automatic logic [ValueWidth-1:0] base_entry(input logic [4:0] idx);
        case (idx)
            5'd17, 5'd19, 5'd22, 5'd24: base_entry = '0;
            default: base_entry = 30'd1;
        endcase
    endfunction

    function automatic logic [ValueWidth-1:0] ident_entry(input logic [4:0] idx);
        case (idx)
            5'd0, 5'd6, 5'd12, 5'd18, 5'd24: ident_entry = 30'd1;
            default: ident_entry = '0;
        endcase
    endfunction

    function automatic logic [ValueWidth-1:0] mod_add(input logic [ValueWidth-1:0] x,
                                                      input logic [ValueWidth-1:0] y);
        logic [ValueWidth:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, Modulus})
            s = s - {1'b0, Modulus};
        mod_add = s[ValueWidth-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/mmps_mem.sv]
`default_nettype none
module mmps_mem
    import mmps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AddrWidth-1:0]  waddr,
    input  wire logic [ValueWidth-1:0] wdata,
    input  wire logic [AddrWidth-1:0]  raddr_a,
    input  wire logic [AddrWidth-1:0]  raddr_b,
    output logic      [ValueWidth-1:0] rdata_a,
    output logic      [ValueWidth-1:0] rdata_b
);

    // Three 25-entry matrices: running square, accumulator, product.
    logic [ValueWidth-1:0] mem [0:3*Cells-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

[hw/rtl/mmps_mulmod.sv]
`default_nettype none
module mmps_mulmod
    import mmps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [ValueWidth-1:0] a,
    input  wire logic [ValueWidth-1:0] b,
    input  wire mmps_tag_t             in_tag,
    output logic                       out_valid,
    output logic      [ValueWidth-1:0] res,
    output mmps_tag_t                  out_tag,
    output logic                       busy
);

    logic [4:0]      v_reg;
    mmps_tag_t       tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [59:0]     x_reg;
    logic [31:0]     x2_reg, x3_reg;
    logic [30:0]     q_reg;
    logic [31:0]     qp_reg;
    logic [31:0]     r_reg;
    logic [ValueWidth-1:0] res_reg;
    logic [61:0]     qm;
    logic [60:0]     qp;
    logic [31:0]     r_red;

    assign qm = x_reg[59:29] * BarrettM;
    assign qp = q_reg * Modulus;

    always_comb
    begin
        if (r_reg >= {1'b0, Modulus, 1'b0})
            r_red = r_reg - {1'b0, Modulus, 1'b0};
        else if (r_reg >= {2'b00, Modulus})
            r_red = r_reg - {2'b00, Modulus};
        else
            r_red = r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    // Barrett reduction: product, quotient estimate, quotient times modulus,
    // remainder below three moduli, final correction.
    always_ff @(posedge clk)
    begin
        x_reg    <= a * b;
        tag1_reg <= in_tag;
        q_reg    <= qm[61:31];
        x2_reg   <= x_reg[31:0];
        tag2_reg <= tag1_reg;
        qp_reg   <= qp[31:0];
        x3_reg   <= x2_reg;
        tag3_reg <= tag2_reg;
        r_reg    <= x3_reg - qp_reg;
        tag4_reg <= tag3_reg;
        res_reg  <= r_red[ValueWidth-1:0];
        tag5_reg <= tag4_reg;
    end

    assign out_valid = v_reg[4];
    assign res       = res_reg;
    assign out_tag   = tag5_reg;
    assign busy      = |v_reg;

endmodule
`default_nettype wire

[hw/rtl/modular_matrix_power_sum_unit.sv]
`default_nettype none
// Modular matrix power sum unit.
// A transaction is offered by raising start with length; it is taken at a
// clock edge where start is high and busy is low. The unit raises the fixed
// 5x5 transition matrix to the power length-1 modulo 999999937 by
// square-and-multiply, least significant exponent bit first, and returns the
// sum of all entries of that power on total, marked by total_valid for
// exactly one cycle. The receiver cannot stall; the result must be taken then.
// All three matrices live in one memory of 75 words with one write port and
// two registered read ports. Each matrix product streams 125 multiply-adds
// through one pipelined Barrett multiplier, one per cycle, then copies the
// product back. There is one product per set bit of length-1 and one squaring
// per exponent bit below its top set bit. busy stays high throughout, so one
// transaction runs at a time. Reset clears the control state only; the memory
// holds scratch data that is rebuilt for every transaction, so no clearing
// pass is needed.
module modular_matrix_power_sum_unit
    import mmps_pkg::*;
#(
    parameter int EXP_BITS = ExpBitsDefault
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [LengthWidth-1:0] length,
    output logic                        total_valid,
    output logic      [ValueWidth-1:0]  total
);

    typedef enum logic [5:0] {
        IDLE  = 6'b000001,
        INIT  = 6'b000010,
        MUL   = 6'b000100,
        DRAIN = 6'b001000,
        COPY  = 6'b010000,
        SUM   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [2:0]            r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [EXP_BITS-1:0]   exp_reg, exp_next;
    logic                  op_acc_reg, op_acc_next;
    logic [ValueWidth-1:0] sum_reg, sum_next;
    logic [ValueWidth-1:0] acc_reg, acc_next;
    logic [ValueWidth-1:0] total_reg, total_next;
    logic                  total_valid_reg, total_valid_next;
    logic                  iss_v_reg, iss_v_next;
    mmps_tag_t             iss_tag_reg, iss_tag_next;

    logic                  mem_we;
    logic [AddrWidth-1:0]  mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [ValueWidth-1:0] mem_wdata, rdata_a, rdata_b;

    logic                  mm_valid, mm_busy;
    logic [ValueWidth-1:0] mm_res;
    mmps_tag_t             mm_tag;
    logic [ValueWidth-1:0] acc_new;

    logic [LengthWidth-1:0] len_m1;
    logic [63:0]            len_ext;
    logic [EXP_BITS-1:0]    exp_shift;
    logic [5:0]             cnt_m;
    logic [AddrWidth-1:0]   left_base, copy_dst;

    assign len_m1    = length - 52'd1;
    assign len_ext   = {12'd0, len_m1};
    assign exp_shift = exp_reg >> 1;
    assign left_base = op_acc_reg ? AccumBase : SquareBase;
    assign copy_dst  = op_acc_reg ? AccumBase : SquareBase;

    mmps_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mmps_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_v_reg),
        .a         (rdata_a),
        .b         (rdata_b),
        .in_tag    (iss_tag_reg),
        .out_valid (mm_valid),
        .res       (mm_res),
        .out_tag   (mm_tag),
        .busy      (mm_busy)
    );

    // Dot-product accumulation of the reduced terms; a cell is complete on its last term.
    assign acc_new  = mm_tag.first ? mm_res : mod_add(acc_reg, mm_res);
    assign acc_next = mm_valid ? acc_new : acc_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        k_next           = k_reg;
        exp_next         = exp_reg;
        op_acc_next      = op_acc_reg;
        sum_next         = sum_reg;
        total_next       = total_reg;
        total_valid_next = 1'b0;
        iss_v_next       = 1'b0;
        iss_tag_next     = '0;
        cnt_m            = cnt_reg - 6'd1;

        // Product cells from the multiplier are written as they complete.
        mem_we      = mm_valid & mm_tag.last;
        mem_waddr   = ProductBase + 7'(mm_tag.idx);
        mem_wdata   = acc_new;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    exp_next   = len_ext[EXP_BITS-1:0];
                    cnt_next   = '0;
                    state_next = INIT;
                end
            end
            INIT:
            begin
                mem_we = 1'b1;
                if (cnt_reg < 6'd25)
                begin
                    mem_waddr = SquareBase + 7'(cnt_reg);
                    mem_wdata = base_entry(cnt_reg[4:0]);
                end
                else
                begin
                    mem_waddr = AccumBase + 7'(cnt_reg - 6'd25);
                    mem_wdata = ident_entry(5'(cnt_reg - 6'd25));
                end
                if (cnt_reg == 6'd49)
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    c_next   = '0;
                    k_next   = '0;
                    sum_next = '0;
                    if (exp_reg == '0)
                        state_next = SUM;
                    else
                    begin
                        op_acc_next = exp_reg[0];
                        state_next  = MUL;
                    end
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            MUL:
            begin
                mem_raddr_a        = left_base + 7'(cell_index(r_reg, k_reg));
                mem_raddr_b        = SquareBase + 7'(cell_index(k_reg, c_reg));
                iss_v_next         = 1'b1;
                iss_tag_next.first = (k_reg == 3'd0);
                iss_tag_next.last  = (k_reg == 3'd4);
                iss_tag_next.idx   = cell_index(r_reg, c_reg);
                if (k_reg == 3'd4)
                begin
                    k_next = '0;
                    if (c_reg == 3'd4)
                    begin
                        c_next = '0;
                        if (r_reg == 3'd4)
                        begin
                            r_next     = '0;
                            state_next = DRAIN;
                        end
                        else
                            r_next = r_reg + 3'd1;
                    end
                    else
                        c_next = c_reg + 3'd1;
                end
                else
                    k_next = k_reg + 3'd1;
            end
            DRAIN:
            begin
                if (!iss_v_reg && !mm_busy)
                begin
                    cnt_next   = '0;
                    state_next = COPY;
                end
            end
            COPY:
            begin
                if (cnt_reg < 6'd25)
                    mem_raddr_a = ProductBase + 7'(cnt_reg);
                if (cnt_reg != 6'd0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = copy_dst + 7'(cnt_m);
                    mem_wdata = rdata_a;
                end
                if (cnt_reg == 6'd25)
                begin
                    cnt_next = '0;
                    sum_next = '0;
                    if (op_acc_reg)
                    begin
                        // No higher bits left: further squarings are not needed.
                        if (exp_shift == '0)
                            state_next = SUM;
                        else
                        begin
                            op_acc_next = 1'b0;
                            state_next  = MUL;
                        end
                    end
                    else
                    begin
                        exp_next    = exp_shift;
                        op_acc_next = exp_shift[0];
                        state_next  = MUL;
                    end
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            SUM:
            begin
                if (cnt_reg < 6'd25)
                    mem_raddr_a = AccumBase + 7'(cnt_reg);
                if (cnt_reg != 6'd0)
                    sum_next = mod_add(sum_reg, rdata_a);
                if (cnt_reg == 6'd25)
                begin
                    total_next       = mod_add(sum_reg, rdata_a);
                    total_valid_next = 1'b1;
                    cnt_next         = '0;
                    state_next       = IDLE;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            cnt_reg         <= '0;
            r_reg           <= '0;
            c_reg           <= '0;
            k_reg           <= '0;
            op_acc_reg      <= 1'b0;
            total_valid_reg <= 1'b0;
            iss_v_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            r_reg           <= r_next;
            c_reg           <= c_next;
            k_reg           <= k_next;
            op_acc_reg      <= op_acc_next;
            total_valid_reg <= total_valid_next;
            iss_v_reg       <= iss_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg     <= exp_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        iss_tag_reg <= iss_tag_next;
    end

    assign busy        = (state_reg != IDLE);
    assign total_valid = total_valid_reg;
    assign total       = total_reg;

    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        total_valid |=> !total_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        total_valid |-> (total < Modulus))
        else $error("result not reduced below the modulus");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!mem_we && !mm_busy))
        else $error("memory or multiplier active while idle");

endmodule
`default_nettype wire

[tb/tb_modular_matrix_power_sum_unit.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_modular_matrix_power_sum_unit;
    import mmps_pkg::*;

    localparam int ExpBits = ExpBitsDefault;
    localparam logic [63:0] Prime = 64'(Modulus);

    // Works out the expected sum for one length and holds it until the
    // matching result comes back from the unit.
    class power_sum_scoreboard;
        logic [ValueWidth-1:0] expected_totals[$];
        int                    mismatches;

        function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b);
            mod_mul = (a * b) % Prime;
        endfunction

        // Square-and-multiply over the low exponent bits, least significant first.
        function automatic logic [ValueWidth-1:0] matrix_power_sum(input logic [LengthWidth-1:0] n);
            logic [63:0]            sq[25];
            logic [63:0]            acc[25];
            logic [63:0]            prod[25];
            logic [LengthWidth-1:0] exponent;
            logic [63:0]            sum;
            logic [63:0]            dot;
            exponent = n - 1'b1;
            for (int i = 0; i < 25; i++)
            begin
                sq[i]  = (i == 17 || i == 19 || i == 22 || i == 24) ? 64'd0 : 64'd1;
                acc[i] = (i % 6 == 0) ? 64'd1 : 64'd0;
            end
            for (int b = 0; b < ExpBits; b++)
            begin
                if (exponent[b])
                begin
                    for (int r = 0; r < 5; r++)
                        for (int c = 0; c < 5; c++)
                        begin
                            dot = 0;
                            for (int k = 0; k < 5; k++)
                                dot = (dot + mod_mul(acc[r*5+k], sq[k*5+c])) % Prime;
                            prod[r*5+c] = dot;
                        end
                    acc = prod;
                end
                for (int r = 0; r < 5; r++)
                    for (int c = 0; c < 5; c++)
                    begin
                        dot = 0;
                        for (int k = 0; k < 5; k++)
                            dot = (dot + mod_mul(sq[r*5+k], sq[k*5+c])) % Prime;
                        prod[r*5+c] = dot;
                    end
                sq = prod;
            end
            sum = 0;
            for (int i = 0; i < 25; i++)
                sum = (sum + acc[i]) % Prime;
            matrix_power_sum = sum[ValueWidth-1:0];
        endfunction

        function void note_length(input logic [LengthWidth-1:0] n);
            expected_totals.push_back(matrix_power_sum(n));
        endfunction

        function void check_total(input logic [ValueWidth-1:0] got);
            logic [ValueWidth-1:0] want;
            if (expected_totals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected total %0d with no transaction outstanding", got);
                return;
            end
            want = expected_totals.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Total mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [LengthWidth-1:0] length = '0;
    logic                   busy;
    logic                   total_valid;
    logic [ValueWidth-1:0]  total;

    power_sum_scoreboard board = new();
    int                     idle_percent = 0;

    always #4 clk = ~clk;

    modular_matrix_power_sum_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .length      (length),
        .total_valid (total_valid),
        .total       (total)
    );

    // Results last one cycle and cannot be held off, so sample every edge.
    always @(posedge clk)
    begin
        if (rst_n && total_valid)
            board.check_total(total);
    end

    // Offers one transaction, optionally after a random pause, and waits until
    // the unit takes it. The expectation is noted at the accepting edge.
    task automatic send_length(input logic [LengthWidth-1:0] n);
        while ($urandom_range(99) < idle_percent)
            @(posedge clk);
        start  <= 1'b1;
        length <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_length(n);
        start <= 1'b0;
        // The unit raises busy after the accepting edge; let it settle.
        @(posedge clk);
    endtask

    // Mostly short exponents keep the run quick; a few use the full width.
    function automatic logic [LengthWidth-1:0] random_length();
        logic [LengthWidth-1:0] n;
        n = 52'({$urandom, $urandom});
        case ($urandom_range(9))
            0:       random_length = n;
            1, 2:    random_length = n & ((52'd1 << $urandom_range(51, 20)) - 52'd1);
            default: random_length = n & ((52'd1 << $urandom_range(16, 1)) - 52'd1);
        endcase
    endfunction

    initial
    begin
        logic [LengthWidth-1:0] directed[$];
        int                     phase_percent[4];
        directed = '{52'd1, 52'd2, 52'd3, 52'd4, 52'd5, 52'd0,
                     52'h8_0000_0000_0000, 52'h8_0000_0000_0001, 52'hF_FFFF_FFFF_FFFF,
                     52'h7_FFFF_FFFF_FFFF, 52'h5_5555_5555_5555, 52'hA_AAAA_AAAA_AAAA,
                     52'd1024, 52'd1025, 52'd999999937};
        phase_percent = '{0, 56, 0, 32};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_length(directed[i]);
        // Receiver stalling cannot happen, so the phases differ only in sender idling.
        for (int p = 0; p < 4; p++)
        begin
            idle_percent = phase_percent[p];
            repeat (22) send_length(random_length());
        end
        while (board.expected_totals.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("** modular_matrix_power_sum_unit: PASSED **");
        else
            $display("** modular_matrix_power_sum_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("** modular_matrix_power_sum_unit: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
